[hw/rtl/gbe_pkg.sv]
// Package for the glyph bitmap expander: shared constants, payload structs,
// configuration and job types. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gbe_pkg;

    // Longest glyph bitmap, in bytes, that is still drawn.
    localparam int MAX_GLYPH_BYTES = 512;
    localparam int BAND_HEIGHT     = 8;
    localparam int TOP_DIVISOR     = 4;

    localparam int ADDR_W   = 32;
    localparam int STRIDE_W = 13;
    localparam int COORD_W  = 12;
    localparam int COL_W    = 8;
    localparam int BAND_W   = 13;
    localparam int ROW_W    = 14;  // origin_y + band_row
    localparam int XCOL_W   = 13;  // origin_x + column_count
    localparam int IDX_W    = (BAND_W - 3) + COL_W + 1;
    localparam int PADDR_W  = 3;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = STRIDE_W'(320);

    typedef enum logic [0:0] {
        REG_FRAME_BASE  = 1'b0,
        REG_LINE_STRIDE = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        MODE_FORE    = 2'd0,
        MODE_BACK    = 2'd1,
        MODE_BOTH    = 2'd2,
        MODE_NOTHING = 2'd3
    } mode_t;

    typedef struct packed {
        logic               glyph_start;
        logic [COORD_W-1:0] origin_x;
        logic [COORD_W-1:0] origin_y;
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic               top_only;
        logic [1:0]         mode;
        logic [7:0]         fore_color;
        logic [7:0]         back_color;
        logic [7:0]         bitmap_byte;
    } src_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] pixel_address;
        logic [7:0]        pixel_value;
        logic              write_enable;
        logic              last_of_byte;
    } pix_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   frame_base;
        logic [STRIDE_W-1:0] line_stride;
    } cfg_t;

    // One bitmap byte, ready for expansion into eight pixel writes.
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [XCOL_W-1:0] col;
        logic [7:0]        we_mask;
        logic [7:0]        fore_mask;
        logic [7:0]        fore_color;
        logic [7:0]        back_color;
    } job_t;

endpackage
`default_nettype wire

[hw/rtl/gbe_cfg.sv]
// APB-style configuration registers: frame base and line stride.
// Depends on gbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbe_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gbe_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output gbe_pkg::cfg_t                    cfg
);
    import gbe_pkg::*;

    logic [ADDR_W-1:0]   frame_base_reg;
    logic [STRIDE_W-1:0] line_stride_reg;
    reg_idx_t            reg_idx;
    logic                wr_en;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg  <= '0;
            line_stride_reg <= STRIDE_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAME_BASE:  frame_base_reg  <= pwdata;
                REG_LINE_STRIDE: line_stride_reg <= pwdata[STRIDE_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_BASE:  prdata = frame_base_reg;
            REG_LINE_STRIDE: prdata = {{(32-STRIDE_W){1'b0}}, line_stride_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.frame_base  = frame_base_reg;
    assign cfg.line_stride = line_stride_reg;

endmodule
`default_nettype wire

[hw/rtl/gbe_front.sv]
// Input register stage: glyph column/band tracking, limit checks and pixel masks.
// Depends on gbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbe_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               src_valid,
    output logic                    src_stall,
    input  wire gbe_pkg::src_item_t src_item,
    output logic                    job_valid,
    input  wire logic               job_take,
    output gbe_pkg::job_t           job
);
    import gbe_pkg::*;

    logic [COL_W-1:0]  col_reg, col_next;
    logic [BAND_W-1:0] band_reg, band_next;
    logic              job_valid_reg, job_valid_next;
    job_t              job_reg, job_next;

    logic              accept;
    logic [COL_W-1:0]  eff_col;
    logic [BAND_W-1:0] eff_band;
    logic [IDX_W-1:0]  idx;
    logic              empty, over, emit;
    logic [6:0]        limit;
    logic              fg_on, bg_on, band0;
    mode_t             mode;

    assign src_stall = job_valid_reg && !job_take;
    assign accept    = src_valid && !src_stall;

    assign mode     = mode_t'(src_item.mode);
    assign eff_col  = src_item.glyph_start ? '0 : col_reg;
    assign eff_band = src_item.glyph_start ? '0 : band_reg;
    assign empty    = (src_item.glyph_width == '0) || (src_item.glyph_height == '0);
    assign idx      = IDX_W'(eff_band[BAND_W-1:3]) * IDX_W'(src_item.glyph_width)
                    + IDX_W'(eff_col);
    assign over     = idx >= IDX_W'(MAX_GLYPH_BYTES);
    assign emit     = !empty && !over;
    assign limit    = 7'(src_item.glyph_height / TOP_DIVISOR) + 7'd1;
    assign band0    = eff_band < BAND_W'(BAND_HEIGHT);
    assign fg_on    = (mode == MODE_FORE) || (mode == MODE_BOTH);
    assign bg_on    = (mode == MODE_BACK) || (mode == MODE_BOTH);

    always_comb
    begin
        col_next  = col_reg;
        band_next = band_reg;
        if (accept)
        begin
            col_next  = eff_col;
            band_next = eff_band;
            if (emit)
            begin
                if ({1'b0, eff_col} + 9'd1 >= {1'b0, src_item.glyph_width})
                begin
                    col_next  = '0;
                    band_next = eff_band + BAND_W'(BAND_HEIGHT);
                end
                else
                begin
                    col_next = eff_col + COL_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        if (accept)
            job_valid_next = emit;
        else if (job_take)
            job_valid_next = 1'b0;
    end

    always_comb
    begin
        job_next            = job_reg;
        job_next.row        = ROW_W'(src_item.origin_y) + ROW_W'(eff_band);
        job_next.col        = XCOL_W'(src_item.origin_x) + XCOL_W'(eff_col);
        job_next.fore_mask  = src_item.bitmap_byte;
        job_next.fore_color = src_item.fore_color;
        job_next.back_color = src_item.back_color;
        for (int b = 0; b < 8; b++)
        begin
            if (src_item.bitmap_byte[b])
                job_next.we_mask[b] = fg_on &&
                    (!src_item.top_only || ((7'(b) < limit) && band0));
            else
                job_next.we_mask[b] = bg_on;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            band_reg      <= '0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            band_reg      <= band_next;
            job_valid_reg <= job_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            job_reg <= job_next;
    end

    assign job_valid = job_valid_reg;
    assign job       = job_reg;

endmodule
`default_nettype wire

[hw/rtl/gbe_expand.sv]
// Expansion stage: walks one job through its eight rows and drives the
// registered pixel write output. Depends on gbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gbe_expand (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire gbe_pkg::cfg_t  cfg,
    input  wire logic           job_valid,
    output logic                job_take,
    input  wire gbe_pkg::job_t  job,
    output logic                pix_valid,
    input  wire logic           pix_stall,
    output gbe_pkg::pix_item_t  pix_item
);
    import gbe_pkg::*;

    logic              work_valid_reg, work_valid_next;
    logic [2:0]        bit_reg, bit_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    job_t              work_reg;
    logic              out_valid_reg, out_valid_next;
    pix_item_t         out_reg, out_next;

    logic              advance, last, load;
    logic [ROW_W+STRIDE_W-1:0] row_off;

    assign advance  = work_valid_reg && (!out_valid_reg || !pix_stall);
    assign last     = (bit_reg == 3'd7);
    assign job_take = !work_valid_reg || (advance && last);
    assign load     = job_take && job_valid;
    assign row_off  = (ROW_W+STRIDE_W)'(job.row) * (ROW_W+STRIDE_W)'(cfg.line_stride);

    always_comb
    begin
        work_valid_next = work_valid_reg;
        bit_next        = bit_reg;
        addr_next       = addr_reg;
        if (load)
        begin
            work_valid_next = 1'b1;
            bit_next        = '0;
            addr_next       = cfg.frame_base + ADDR_W'(row_off) + ADDR_W'(job.col);
        end
        else if (advance && last)
        begin
            work_valid_next = 1'b0;
        end
        else if (advance)
        begin
            bit_next  = bit_reg + 3'd1;
            addr_next = addr_reg + ADDR_W'(cfg.line_stride);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next         = 1'b1;
            out_next.pixel_address = addr_reg;
            out_next.write_enable  = work_reg.we_mask[bit_reg];
            out_next.last_of_byte  = last;
            if (!work_reg.we_mask[bit_reg])
                out_next.pixel_value = '0;
            else if (work_reg.fore_mask[bit_reg])
                out_next.pixel_value = work_reg.fore_color;
            else
                out_next.pixel_value = work_reg.back_color;
        end
        else if (!pix_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            bit_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            bit_reg        <= bit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        out_reg  <= out_next;
        if (load)
            work_reg <= job;
    end

    assign pix_valid = out_valid_reg;
    assign pix_item  = out_reg;

endmodule
`default_nettype wire

[hw/rtl/glyph_bitmap_expander.sv]
// Top level of the glyph bitmap expander: configuration port, input stage and
// expansion stage. Depends on gbe_pkg, gbe_cfg, gbe_front and gbe_expand.
`timescale 1ns / 1ps
`default_nettype none
// Takes one byte of a column-major, 8-pixel-band glyph bitmap per src
// transaction and issues eight byte-per-pixel frame buffer writes on the pix
// channel, bit 0 (topmost row) first, last_of_byte marking the eighth. Each
// write lands at frame_base + (origin_y + band + bit) * line_stride + origin_x +
// column, modulo 2^32. Empty glyphs (zero width or height) and bytes beyond
// MAX_GLYPH_BYTES produce no transactions but still take a glyph_start restart.
// Rate: one pixel transaction per clock while pix_stall is low, so a byte
// takes eight transactions on the output; the pix output register is the
// limiting unit. The next byte is taken into the input register while the
// current one is still expanding, so a steady stream has no gaps on pix.
// A byte passes the job, work and pix output registers on its way to pix.
// The user must write configuration (frame_base at 0x0, line_stride at 0x4)
// only while the block is idle; the block itself does not enforce this.
module glyph_bitmap_expander (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration port
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [gbe_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    // bitmap bytes in
    input  wire logic                        src_valid,
    output logic                             src_stall,
    input  wire gbe_pkg::src_item_t          src_item,
    // pixel writes out
    output logic                             pix_valid,
    input  wire logic                        pix_stall,
    output gbe_pkg::pix_item_t               pix_item
);
    import gbe_pkg::*;

    cfg_t cfg;
    job_t job;
    logic job_valid;
    logic job_take;

    // Hold the frame base and stride.
    gbe_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Track column and band, drop out-of-range bytes, build the write masks.
    gbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    // Advance through the eight rows, one pixel transaction per cycle while pix is not stalled.
    gbe_expand u_expand (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_item  (pix_item)
    );

endmodule
`default_nettype wire

[verif/glyph_bitmap_expander_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for glyph_bitmap_expander: APB register writes, bitmap
// byte transactions in, pixel write transactions checked in order against a local
// predictor. Depends on gbe_pkg and the glyph_bitmap_expander RTL.
module glyph_bitmap_expander_tb;
    import gbe_pkg::*;

    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 7;
    // Margin for anything still in flight after the predicted writes are seen.
    localparam int DRAIN_PAUSE  = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int PRINT_CAP    = 40;

    // Every block input starts at a known value.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [31:0]          pwdata    = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 src_valid = 1'b0;
    logic                 src_stall;
    src_item_t            src_item  = '0;
    logic                 pix_valid;
    logic                 pix_stall = 1'b0;
    pix_item_t            pix_item;

    // Predictor state: register copies and the glyph walk position.
    logic [ADDR_W-1:0]    base_shadow   = '0;
    logic [STRIDE_W-1:0]  stride_shadow = STRIDE_RESET;
    logic [COL_W-1:0]     column_pos    = '0;
    logic [BAND_W-1:0]    band_pos      = '0;

    // Pixel writes predicted but not yet seen on the pix channel, oldest first.
    pix_item_t            pixel_writes_due[$];

    int mismatches     = 0;
    int bytes_expanded = 0;
    int bytes_dropped  = 0;
    int pixels_checked = 0;
    int reg_writes     = 0;
    int cycles         = 0;
    int tx_idle_pct    = 0;
    int rx_stall_pct   = 0;
    int hold_left      = 0;

    glyph_bitmap_expander dut (
        .clk,
        .rst_n,
        .psel,
        .penable,
        .pwrite,
        .paddr,
        .pwdata,
        .prdata,
        .pready,
        .src_valid,
        .src_stall,
        .src_item,
        .pix_valid,
        .pix_stall,
        .pix_item
    );

    always
    begin
        #CLK_HIGH clk = 1'b1;
        #CLK_LOW  clk = 1'b0;
    end

    // Bound the run; a hang or a lost pixel write ends here.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d pixel writes outstanding",
                     cycles, pixel_writes_due.size());
            $display("glyph_bitmap_expander_tb: errors");
            $finish;
        end
    end

    // Count the failure; print only the first few so a broken block stays readable.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("[%0t] mismatch %s: got 0x%08h expected 0x%08h", $time, what, got, want);
    endtask

    // Expand one accepted bitmap byte into its eight pixel writes and advance the
    // column/band walk. Empty glyphs and bytes past the glyph size cap only honor
    // a glyph_start restart.
    function automatic void expand_byte(input src_item_t it);
        mode_t       m;
        logic        fg_on;
        logic        bg_on;
        logic [31:0] glyph_index;
        logic [31:0] top_rows;
        logic [31:0] row;
        pix_item_t   px;
        m     = mode_t'(it.mode);
        fg_on = (m == MODE_FORE) || (m == MODE_BOTH);
        bg_on = (m == MODE_BACK) || (m == MODE_BOTH);
        if (it.glyph_start)
        begin
            column_pos = '0;
            band_pos   = '0;
        end
        if (it.glyph_width == 0 || it.glyph_height == 0)
        begin
            bytes_dropped++;
            return;
        end
        glyph_index = 32'(band_pos / BAND_HEIGHT) * 32'(it.glyph_width) + 32'(column_pos);
        if (glyph_index >= MAX_GLYPH_BYTES)
        begin
            bytes_dropped++;
            return;
        end
        // Top-only glyphs (combining marks) keep foreground to the first height/4+1
        // rows of band 0.
        top_rows = 32'(it.glyph_height) / TOP_DIVISOR + 1;
        for (int b = 0; b < 8; b++)
        begin
            row = 32'(it.origin_y) + 32'(band_pos) + 32'(b);
            px.pixel_address = base_shadow + row * 32'(stride_shadow)
                               + 32'(it.origin_x) + 32'(column_pos);
            px.pixel_value   = '0;
            px.write_enable  = 1'b0;
            if (it.bitmap_byte[b])
            begin
                if (fg_on && (!it.top_only || (b < top_rows && band_pos < BAND_HEIGHT)))
                begin
                    px.write_enable = 1'b1;
                    px.pixel_value  = it.fore_color;
                end
            end
            else if (bg_on)
            begin
                px.write_enable = 1'b1;
                px.pixel_value  = it.back_color;
            end
            px.last_of_byte = (b == 7);
            pixel_writes_due.push_back(px);
        end
        // Wrap on >= so a width shrunk mid-glyph still moves to the next band.
        if (32'(column_pos) + 1 >= 32'(it.glyph_width))
        begin
            column_pos = '0;
            band_pos   = band_pos + BAND_W'(BAND_HEIGHT);
        end
        else
            column_pos = column_pos + 1'b1;
        bytes_expanded++;
    endfunction

    // Predict on every src transaction, at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && src_valid && !src_stall)
            expand_byte(src_item);
    end

    // Check each pix transaction field by field against the oldest prediction.
    always @(posedge clk)
    begin
        pix_item_t want;
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (pixel_writes_due.size() == 0)
                report_mismatch("unexpected pixel write at address",
                                pix_item.pixel_address, '0);
            else
            begin
                want = pixel_writes_due.pop_front();
                pixels_checked++;
                if (pix_item.pixel_address !== want.pixel_address)
                    report_mismatch("pixel_address", pix_item.pixel_address,
                                    want.pixel_address);
                if (pix_item.pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", 32'(pix_item.pixel_value),
                                    32'(want.pixel_value));
                if (pix_item.write_enable !== want.write_enable)
                    report_mismatch("write_enable", 32'(pix_item.write_enable),
                                    32'(want.write_enable));
                if (pix_item.last_of_byte !== want.last_of_byte)
                    report_mismatch("last_of_byte", 32'(pix_item.last_of_byte),
                                    32'(want.last_of_byte));
            end
        end
    end

    // Drive the pix stall: a long hold-off when one is pending, else random stalls.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            pix_stall <= 1'b1;
            hold_left--;
        end
        else
            pix_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Offer one byte, with random idle cycles first; return at the accepting edge.
    // Valid stays high into the next call so back-to-back bytes see no gap.
    task automatic send_byte(input src_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every predicted pixel write, then let the pipe settle.
    task automatic drain_pixels;
        src_valid <= 1'b0;
        @(posedge clk);
        while (pixel_writes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // APB write followed by a read-back; call only while the block is idle.
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] readback;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        // Turn the same select into a read of the register just written.
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_FRAME_BASE:
            begin
                base_shadow = value;
                if (readback !== value)
                    report_mismatch("frame_base read-back", readback, value);
            end
            REG_LINE_STRIDE:
            begin
                stride_shadow = value[STRIDE_W-1:0];
                if (readback[STRIDE_W-1:0] !== value[STRIDE_W-1:0])
                    report_mismatch("line_stride read-back", 32'(readback[STRIDE_W-1:0]),
                                    32'(value[STRIDE_W-1:0]));
            end
            default: ;
        endcase
    endtask

    function automatic src_item_t glyph_byte(input logic start, input int ox, input int oy,
                                             input int w, input int h, input logic top,
                                             input mode_t m, input logic [7:0] fc,
                                             input logic [7:0] bc, input logic [7:0] bits);
        src_item_t it;
        it.glyph_start  = start;
        it.origin_x     = COORD_W'(ox);
        it.origin_y     = COORD_W'(oy);
        it.glyph_width  = 8'(w);
        it.glyph_height = 8'(h);
        it.top_only     = top;
        it.mode         = m;
        it.fore_color   = fc;
        it.back_color   = bc;
        it.bitmap_byte  = bits;
        return it;
    endfunction

    function automatic src_item_t random_item();
        logic [95:0] raw;
        src_item_t   it;
        raw = {$urandom, $urandom, $urandom};
        it  = raw[$bits(src_item_t)-1:0];
        return it;
    endfunction

    // Coordinates, sizes and colors at their ends, plus a frame_base that wraps.
    task automatic test_field_extremes;
        send_byte(glyph_byte(1, 0, 0, 1, 1, 0, MODE_FORE, 8'hFF, 8'h00, 8'hFF));
        send_byte(glyph_byte(1, 4095, 4095, 255, 255, 0, MODE_BOTH, 8'h00, 8'hFF, 8'hA5));
        send_byte(glyph_byte(0, 4095, 4095, 255, 255, 0, MODE_BOTH, 8'hFF, 8'h00, 8'h5A));
        drain_pixels();
        write_reg(REG_FRAME_BASE, 32'hFFFF_FFF0);
        write_reg(REG_LINE_STRIDE, 32'd4096);
        // Hold the address sum past 2^32 so it has to wrap.
        send_byte(glyph_byte(1, 4095, 4095, 3, 200, 0, MODE_BOTH, 8'h81, 8'h7E, 8'h00));
        drain_pixels();
    endtask

    // One byte per mode, nothing mode included.
    task automatic test_modes;
        mode_t all_modes[4];
        all_modes = '{MODE_FORE, MODE_BACK, MODE_BOTH, MODE_NOTHING};
        foreach (all_modes[i])
            send_byte(glyph_byte(1, 100, 50, 2, 8, 0, all_modes[i], 8'hC3, 8'h3C, 8'h96));
        drain_pixels();
    endtask

    // Top-only: foreground cut below height/4+1 rows and outside band 0.
    task automatic test_top_only;
        send_byte(glyph_byte(1, 10, 20, 1, 12, 1, MODE_BOTH, 8'h11, 8'h22, 8'hFF));
        send_byte(glyph_byte(0, 10, 20, 1, 12, 1, MODE_BOTH, 8'h11, 8'h22, 8'hF0));
        send_byte(glyph_byte(1, 10, 20, 2, 3, 1, MODE_FORE, 8'h33, 8'h44, 8'h03));
        drain_pixels();
    endtask

    // Empty glyphs, the glyph size cap exactly at its edge, and a width shrunk
    // mid-glyph.
    task automatic test_empty_and_overlong;
        send_byte(glyph_byte(1, 5, 5, 0, 8, 0, MODE_BOTH, 8'h01, 8'h02, 8'hAA));
        send_byte(glyph_byte(1, 5, 5, 4, 0, 0, MODE_BOTH, 8'h01, 8'h02, 8'hAA));
        send_byte(glyph_byte(0, 5, 5, 4, 8, 0, MODE_BOTH, 8'h01, 8'h02, 8'hAA));
        // Two one-byte bands, then width 255: glyph index lands on 510, 511, 512.
        send_byte(glyph_byte(1, 0, 0, 1, 8, 0, MODE_FORE, 8'h09, 8'h0A, 8'h0F));
        send_byte(glyph_byte(0, 0, 0, 1, 8, 0, MODE_FORE, 8'h09, 8'h0A, 8'hF0));
        send_byte(glyph_byte(0, 0, 0, 255, 8, 0, MODE_BOTH, 8'h09, 8'h0A, 8'h11));
        send_byte(glyph_byte(0, 0, 0, 255, 8, 0, MODE_BOTH, 8'h09, 8'h0A, 8'h22));
        send_byte(glyph_byte(0, 0, 0, 255, 8, 0, MODE_BOTH, 8'h09, 8'h0A, 8'h44));
        // Width drops to 2 with the column already at 2: wrap to the next band.
        send_byte(glyph_byte(0, 0, 0, 2, 8, 0, MODE_BOTH, 8'h09, 8'h0A, 8'h88));
        drain_pixels();
    endtask

    // Zero stride folds all rows onto one; then the smallest and largest strides.
    task automatic test_stride_extremes;
        logic [31:0] strides[3];
        strides = '{32'd0, 32'd1, 32'd8191};
        write_reg(REG_FRAME_BASE, 32'h0000_0000);
        foreach (strides[i])
        begin
            write_reg(REG_LINE_STRIDE, strides[i]);
            send_byte(glyph_byte(1, 7, 4000, 1, 16, 0, MODE_BOTH, 8'h5C, 8'hC5, 8'h69));
            drain_pixels();
        end
    endtask

    // One glyph drawn byte by byte in walk order; sometimes cut short.
    task automatic send_random_glyph(inout int sent);
        src_item_t it;
        int        nbytes;
        it              = random_item();
        it.glyph_start  = 1'b1;
        it.glyph_width  = ($urandom_range(9) == 0) ? 8'($urandom_range(9, 40))
                                                   : 8'($urandom_range(1, 6));
        it.glyph_height = ($urandom_range(7) == 0) ? 8'($urandom_range(25, 255))
                                                   : 8'($urandom_range(1, 24));
        it.top_only     = ($urandom_range(3) == 0);
        nbytes = int'(it.glyph_width) * ((int'(it.glyph_height) + 7) / 8);
        if (nbytes > 30)
            nbytes = 30;
        if ($urandom_range(7) == 0)
            nbytes = $urandom_range(1, nbytes);
        for (int i = 0; i < nbytes; i++)
        begin
            it.bitmap_byte = 8'($urandom);
            send_byte(it);
            it.glyph_start = 1'b0;
            sent++;
        end
    endtask

    // Mostly well-formed glyphs; the rest raw random bytes, some of them empty.
    task automatic test_random_phase(input int tx_pct, input int rx_pct, input int quota);
        src_item_t it;
        int        sent;
        sent = 0;
        drain_pixels();
        write_reg(REG_FRAME_BASE, $urandom);
        write_reg(REG_LINE_STRIDE, 32'($urandom_range(1, 4096)));
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        while (sent < quota)
        begin
            if ($urandom_range(99) < 80)
                send_random_glyph(sent);
            else
            begin
                it = random_item();
                if ($urandom_range(4) == 0)
                    it.glyph_height = '0;
                if (it.glyph_width != 0 && it.glyph_height != 0)
                    sent++;
                send_byte(it);
            end
        end
        drain_pixels();
    endtask

    // Hold pix off long enough that the block fills and stalls src, while the
    // sender keeps offering.
    task automatic test_back_pressure;
        int sent;
        sent         = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        @(negedge clk);
        hold_left = LONG_HOLD;
        @(posedge clk);
        while (sent < 16)
            send_random_glyph(sent);
        drain_pixels();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modes();
        test_top_only();
        test_empty_and_overlong();
        test_field_extremes();
        test_stride_extremes();
        test_back_pressure();
        test_random_phase(0, 0, 105);
        test_random_phase(69, 0, 95);
        test_random_phase(0, 69, 95);
        test_random_phase(38, 38, 105);

        $display("covered %0d expanded bytes and %0d dropped bytes, %0d pixel writes checked",
                 bytes_expanded, bytes_dropped, pixels_checked);
        $display("over %0d register writes, four idle/stall mixes and a long output hold-off",
                 reg_writes);
        if (mismatches == 0)
            $display("glyph_bitmap_expander_tb: clean");
        else
            $display("glyph_bitmap_expander_tb: errors");
        $finish;
    end

endmodule

[glyph_bitmap_expander.f]
hw/rtl/gbe_pkg.sv
hw/rtl/gbe_cfg.sv
hw/rtl/gbe_front.sv
hw/rtl/gbe_expand.sv
hw/rtl/glyph_bitmap_expander.sv
verif/glyph_bitmap_expander_tb.sv
